// ===== hw/rtl/gosa_pkg.sv =====
// ============================================================================
// gosa_pkg
// Shared types, register indexes, rule bits and character classes for the
// glyph overlap smush amount block.
// ============================================================================
`default_nettype none

package gosa_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SMUSH_MODE    = 2'd0,
    CFG_HARD_BLANK    = 2'd1,
    CFG_RIGHT_TO_LEFT = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Bit positions in smush_mode.
  localparam int unsigned ModeEqualBit   = 0;
  localparam int unsigned ModeLowlineBit = 1;
  localparam int unsigned ModeHierBit    = 2;
  localparam int unsigned ModePairBit    = 3;
  localparam int unsigned ModeBigxBit    = 4;
  localparam int unsigned ModeHardBit    = 5;
  localparam int unsigned ModeKernBit    = 6;
  localparam int unsigned ModeSmushBit   = 7;

  localparam logic [7:0] ModeReset     = 8'd64;
  localparam logic [7:0] HardBlankReset = 8'd36;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChBar    = 8'h7C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLbrack = 8'h5B;
  localparam logic [7:0] ChRbrack = 8'h5D;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChLess   = 8'h3C;
  localparam logic [7:0] ChGreater = 8'h3E;
  localparam logic [7:0] ChUnder  = 8'h5F;

  typedef struct packed {
    logic [7:0] left_char;
    logic [7:0] right_char;
    logic [7:0] left_edge_pos;
    logic [7:0] right_lead_blanks;
    logic [7:0] left_width;
    logic [7:0] line_length;
    logic [7:0] glyph_width;
    logic [7:0] prev_width;
    logic       first_row;
    logic       last_row;
  } row_t;

  typedef struct packed {
    logic [7:0] overlap_amount;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // Register file as seen by the datapath.
  typedef struct packed {
    logic [7:0] smush_mode;
    logic [7:0] hard_blank;
    logic       right_to_left;
  } cfg_t;

  function automatic logic in_lowline_set(input logic [7:0] c);
    case (c) inside
      ChBar, ChSlash, ChBslash, ChLbrack, ChRbrack, ChLbrace, ChRbrace,
      ChLparen, ChRparen, ChLess, ChGreater: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic in_bar_set(input logic [7:0] c);
    case (c) inside
      ChSlash, ChBslash, ChLbrack, ChRbrack, ChLbrace, ChRbrace,
      ChLparen, ChRparen, ChLess, ChGreater: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic in_brack_set(input logic [7:0] c);
    case (c) inside
      ChLbrack, ChRbrack, ChLbrace, ChRbrace, ChLparen, ChRparen,
      ChLess, ChGreater: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic in_brace_set(input logic [7:0] c);
    case (c) inside
      ChLbrace, ChRbrace, ChLparen, ChRparen, ChLess, ChGreater: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic in_paren_set(input logic [7:0] c);
    case (c) inside
      ChLparen, ChRparen, ChLess, ChGreater: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gosa_row_if.sv =====
// ============================================================================
// gosa_row_if
// Valid/ready channel carrying one glyph row item.
// ============================================================================
`default_nettype none

interface gosa_row_if;
  import gosa_pkg::*;

  logic valid;
  logic ready;
  row_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gosa_res_if.sv =====
// ============================================================================
// gosa_res_if
// Valid/ready channel carrying one overlap result.
// ============================================================================
`default_nettype none

interface gosa_res_if;
  import gosa_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gosa_cfg_if.sv =====
// ============================================================================
// gosa_cfg_if
// Valid/ready write channel for the configuration registers.
// ============================================================================
`default_nettype none

interface gosa_cfg_if;
  import gosa_pkg::*;

  logic    valid;
  logic    ready;
  cfg_wr_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/glyph_overlap_smush_amount.sv =====
// ============================================================================
// glyph_overlap_smush_amount
// Works out how many columns a new glyph may slide into the text line. One
// row item per glyph row enters on row_i; each row's overlap is found from
// the boundary characters and positions under the merge rules selected in
// smush_mode, and a running minimum starts at the glyph width on the first
// row. The row flagged last_row gives one result on res_o, which is zero
// when neither the smush nor the kern bit is set. The block takes one row
// per cycle while no last row is stalled: a row is held in an input
// register, evaluated by compare and add logic, and its result lands in
// the output register when the row advances, so res_o is registered
// after the input register. A waiting result stalls only a following last
// row, which then holds back the row input; configuration writes on cfg_i
// are always taken and must be made while no rows are in flight.
// ============================================================================
`default_nettype none

module glyph_overlap_smush_amount (
  input  logic clk_i,
  input  logic rst_ni,
  gosa_cfg_if.sink   cfg_i,
  gosa_row_if.sink   row_i,
  gosa_res_if.source res_o
);
  import gosa_pkg::*;

  cfg_t       cfg_q;
  row_t       s1_q;
  logic       s1_valid_q;
  logic       s1_adv;
  logic [7:0] running_min_q, min_d;
  logic       out_valid_q;
  logic [7:0] out_q;

  logic       merge_ok;
  logic       row_inc;
  logic [7:0] m_start, m_capped;
  logic [9:0] amt;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smush_mode    <= ModeReset;
      cfg_q.hard_blank    <= HardBlankReset;
      cfg_q.right_to_left <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_SMUSH_MODE:    cfg_q.smush_mode    <= cfg_i.data.data;
        CFG_HARD_BLANK:    cfg_q.hard_blank    <= cfg_i.data.data;
        CFG_RIGHT_TO_LEFT: cfg_q.right_to_left <= cfg_i.data.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  // A row without last_row never needs the output register.
  assign s1_adv = s1_valid_q && (!s1_q.last_row || !out_valid_q || res_o.ready);
  assign row_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (row_i.ready) begin
      s1_valid_q <= row_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_i.ready && row_i.valid) begin
      s1_q <= row_i.data;
    end
  end

  // ---------------------------------------------------------------------
  // Row evaluation
  // ---------------------------------------------------------------------
  gosa_merge u_merge (
    .cfg_i         (cfg_q),
    .left_char_i   (s1_q.left_char),
    .right_char_i  (s1_q.right_char),
    .prev_width_i  (s1_q.prev_width),
    .glyph_width_i (s1_q.glyph_width),
    .merge_ok_o    (merge_ok)
  );

  always_comb begin
    if ((s1_q.left_char == ChNul) || (s1_q.left_char == ChSpace)) begin
      row_inc = 1'b1;
    end else begin
      row_inc = (s1_q.right_char != ChNul) && merge_ok;
    end

    m_start  = s1_q.first_row ? s1_q.glyph_width : running_min_q;
    m_capped = (cfg_q.right_to_left && (s1_q.line_length < m_start)) ?
               s1_q.line_length : m_start;

    // Two's complement in ten bits covers -256 to 510.
    amt = {2'b00, s1_q.right_lead_blanks} + {2'b00, s1_q.left_width}
        - {2'b00, s1_q.left_edge_pos} - 10'd1 + {9'd0, row_inc};

    // A negative row amount leaves the minimum alone.
    if (!amt[9] && (amt[8:0] < {1'b0, m_capped})) begin
      min_d = amt[7:0];
    end else begin
      min_d = m_capped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_min_q <= '0;
    end else if (s1_adv) begin
      running_min_q <= min_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.last_row) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.last_row) begin
      out_q <= (cfg_q.smush_mode[ModeSmushBit] || cfg_q.smush_mode[ModeKernBit]) ?
               min_d : 8'd0;
    end
  end

  assign res_o.valid               = out_valid_q;
  assign res_o.data.overlap_amount = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_last_row_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.last_row) |=> out_valid_q)
    else $error("last row advanced without producing a result");

  a_stall_means_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !row_i.ready |-> (s1_valid_q && s1_q.last_row && out_valid_q))
    else $error("input stalled without a blocked last row");

  a_min_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.first_row) |=> (running_min_q <= $past(s1_q.glyph_width)))
    else $error("running minimum exceeds glyph width after first row");

  a_rtl_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && cfg_q.right_to_left) |=> (running_min_q <= $past(s1_q.line_length)))
    else $error("running minimum exceeds line length in right-to-left mode");

endmodule

`default_nettype wire

// ===== hw/rtl/gosa_merge.sv =====
// ============================================================================
// gosa_merge
// Decides whether two boundary characters merge into one under the
// enabled smushing rules.
// ============================================================================
`default_nettype none

module gosa_merge (
  input  gosa_pkg::cfg_t cfg_i,
  input  logic [7:0]     left_char_i,
  input  logic [7:0]     right_char_i,
  input  logic [7:0]     prev_width_i,
  input  logic [7:0]     glyph_width_i,
  output logic           merge_ok_o
);
  import gosa_pkg::*;

  logic [7:0] l, r, hb, mode;
  logic       l_hb, r_hb;
  logic       rule_equal, rule_low, rule_hier, rule_pair, rule_bigx;

  assign l    = left_char_i;
  assign r    = right_char_i;
  assign hb   = cfg_i.hard_blank;
  assign mode = cfg_i.smush_mode;
  assign l_hb = (l == hb);
  assign r_hb = (r == hb);

  always_comb begin
    rule_equal = mode[ModeEqualBit] && (l == r);

    rule_low = mode[ModeLowlineBit] &&
               (((l == ChUnder) && in_lowline_set(r)) ||
                ((r == ChUnder) && in_lowline_set(l)));

    rule_hier = mode[ModeHierBit] &&
                (((l == ChBar) && in_bar_set(r)) ||
                 ((r == ChBar) && in_bar_set(l)) ||
                 (((l == ChSlash) || (l == ChBslash)) && in_brack_set(r)) ||
                 (((r == ChSlash) || (r == ChBslash)) && in_brack_set(l)) ||
                 (((l == ChLbrack) || (l == ChRbrack)) && in_brace_set(r)) ||
                 (((r == ChLbrack) || (r == ChRbrack)) && in_brace_set(l)) ||
                 (((l == ChLbrace) || (l == ChRbrace)) && in_paren_set(r)) ||
                 (((r == ChLbrace) || (r == ChRbrace)) && in_paren_set(l)) ||
                 (((l == ChLparen) || (l == ChRparen)) &&
                  ((r == ChLess) || (r == ChGreater))) ||
                 (((r == ChLparen) || (r == ChRparen)) &&
                  ((l == ChLess) || (l == ChGreater))));

    rule_pair = mode[ModePairBit] &&
                (((l == ChLbrack) && (r == ChRbrack)) ||
                 ((r == ChLbrack) && (l == ChRbrack)) ||
                 ((l == ChLbrace) && (r == ChRbrace)) ||
                 ((r == ChLbrace) && (l == ChRbrace)) ||
                 ((l == ChLparen) && (r == ChRparen)) ||
                 ((r == ChLparen) && (l == ChRparen)));

    rule_bigx = mode[ModeBigxBit] &&
                (((l == ChSlash) && (r == ChBslash)) ||
                 ((r == ChSlash) && (l == ChBslash)) ||
                 ((l == ChGreater) && (r == ChLess)));

    // Every rule that fires yields a nonzero character, so only the
    // early rejections matter for the outcome.
    if ((l == ChSpace) || (r == ChSpace)) begin
      merge_ok_o = 1'b1;
    end else if ((prev_width_i < 8'd2) || (glyph_width_i < 8'd2)) begin
      merge_ok_o = 1'b0;
    end else if (!mode[ModeSmushBit]) begin
      merge_ok_o = 1'b0;
    end else if (mode[ModeHardBit:0] == '0) begin
      merge_ok_o = 1'b1;
    end else if (mode[ModeHardBit] && l_hb && r_hb) begin
      merge_ok_o = 1'b1;
    end else if (l_hb || r_hb) begin
      merge_ok_o = 1'b0;
    end else begin
      merge_ok_o = rule_equal || rule_low || rule_hier || rule_pair || rule_bigx;
    end
  end

endmodule

`default_nettype wire
